// ===== src/bat_pkg.sv =====
`timescale 1ns / 1ps

package bat_pkg;

  // Table capacity and field widths
  localparam int DEPTH   = 16;
  localparam int IDX_W   = 5;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int CMD_W   = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]         idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT   = 3'd0,
    CMD_GET    = 3'd1,
    CMD_SET    = 3'd2,
    CMD_PUSH   = 3'd3,
    CMD_INSERT = 3'd4,
    CMD_FIND   = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Per-cell control, decoded once per accepted word
  typedef struct packed {
    logic clear;  // zero the entry
    logic wr;     // load the command value
    logic shift;  // take the left neighbor's entry
    logic live;   // entry lies below the current length
    logic sel;    // entry addressed by the index field
  } cell_ctrl_t;

endpackage

// ===== src/bat_cell.sv =====
`timescale 1ns / 1ps

module bat_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  bat_pkg::cell_ctrl_t ctrl,
  input  bat_pkg::word_t      value_i,
  input  bat_pkg::word_t      left_i,
  input  logic                hit_i,
  output bat_pkg::word_t      entry_o,
  output bat_pkg::word_t      rd_o,
  output logic                hit_o,
  output logic                first_o
);

  bat_pkg::word_t entry_r;
  bat_pkg::word_t entry_nxt;
  logic           hit;

  // Clear wins over write, write over shift
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.clear) begin
      entry_nxt = '0;
    end else if (ctrl.wr) begin
      entry_nxt = value_i;
    end else if (ctrl.shift) begin
      entry_nxt = left_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  // Search: pass the match flag up the row, flag the lowest match
  assign hit     = ctrl.live && (entry_r == value_i);
  assign hit_o   = hit_i | hit;
  assign first_o = hit & ~hit_i;

  assign entry_o = entry_r;
  assign rd_o    = ctrl.sel ? entry_r : '0;

endmodule

// ===== src/bounded_array_table.sv =====
`timescale 1ns / 1ps
// Channel | Dir | tdata fields (lowest bit up)                           | Width
// in_     | in  | command[2:0], index[7:3], value[39:8]                  | 40
// out_    | out | status[1:0], read_value[33:2], found_index[38:34],     | 48
//         |     | length[43:39], zero fill[47:44]                        |
//
// One word is accepted per cycle while in_tready is high; its result appears in
// the output register on the next cycle. Every command finishes as it is accepted
// because each entry sits in its own cell: insert shifts all cells at once, find
// compares in all cells at once and the match flag ripples down the row of cells.
// Reset (synchronous, rst_n low) empties the table and drops any pending result.
// A stalled output holds its word; in_tready stays high while the output
// register is empty or being drained.

module bounded_array_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // command[2:0], index[7:3], value[39:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[1:0], read_value[33:2],
                                  // found_index[38:34], length[43:39]
);

  localparam int DEPTH = bat_pkg::DEPTH;

  // Unpack the input word
  logic [bat_pkg::CMD_W-1:0] in_command;
  bat_pkg::idx_t             in_index;
  bat_pkg::word_t            in_value;

  assign in_command = in_tdata[2:0];
  assign in_index   = in_tdata[7:3];
  assign in_value   = in_tdata[39:8];

  // Control state and output register
  bat_pkg::idx_t    len_r;
  bat_pkg::idx_t    len_nxt;
  logic             out_valid_r;
  bat_pkg::status_t status_r;
  bat_pkg::status_t status_nxt;
  bat_pkg::word_t   rd_r;
  bat_pkg::word_t   rd_nxt;
  bat_pkg::idx_t    found_r;
  bat_pkg::idx_t    found_nxt;

  logic acc;
  logic init_ok, get_ok, set_ok, push_ok, ins_ok, find_op;

  // Take a new word whenever the output register is free or draining
  assign in_tready = ~out_valid_r | out_tready;
  assign acc       = in_tvalid & in_tready;

  // Command decode with range and fullness checks
  always_comb begin
    init_ok    = 1'b0;
    get_ok     = 1'b0;
    set_ok     = 1'b0;
    push_ok    = 1'b0;
    ins_ok     = 1'b0;
    find_op    = 1'b0;
    status_nxt = bat_pkg::ST_OK;
    unique case (bat_pkg::cmd_t'(in_command))
      bat_pkg::CMD_INIT: begin
        if (in_index > bat_pkg::idx_t'(DEPTH)) begin
          status_nxt = bat_pkg::ST_BAD_INDEX;
        end else begin
          init_ok = 1'b1;
        end
      end
      bat_pkg::CMD_GET: begin
        if (in_index >= len_r) begin
          status_nxt = bat_pkg::ST_BAD_INDEX;
        end else begin
          get_ok = 1'b1;
        end
      end
      bat_pkg::CMD_SET: begin
        if (in_index >= len_r) begin
          status_nxt = bat_pkg::ST_BAD_INDEX;
        end else begin
          set_ok = 1'b1;
        end
      end
      bat_pkg::CMD_PUSH: begin
        if (len_r == bat_pkg::idx_t'(DEPTH)) begin
          status_nxt = bat_pkg::ST_FULL;
        end else begin
          push_ok = 1'b1;
        end
      end
      bat_pkg::CMD_INSERT: begin
        // range is checked before fullness
        if (in_index >= len_r) begin
          status_nxt = bat_pkg::ST_BAD_INDEX;
        end else if (len_r == bat_pkg::idx_t'(DEPTH)) begin
          status_nxt = bat_pkg::ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      bat_pkg::CMD_FIND: begin
        find_op = 1'b1;
      end
      default: begin
        // unused codes change nothing and report ok
      end
    endcase
  end

  // Row of cells
  bat_pkg::cell_ctrl_t ctrl [DEPTH];
  bat_pkg::word_t      entry [DEPTH];
  bat_pkg::word_t      rd_cell [DEPTH];
  logic [DEPTH-1:0]    hit_chain;
  logic [DEPTH-1:0]    first;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bat_pkg::word_t left;
    logic           hit_in;

    if (i == 0) begin : g_head
      assign left   = '0;
      assign hit_in = 1'b0;
    end else begin : g_body
      assign left   = entry[i-1];
      assign hit_in = hit_chain[i-1];
    end

    assign ctrl[i].clear = acc & init_ok;
    assign ctrl[i].wr    = acc & ((((set_ok | ins_ok) & (in_index == bat_pkg::idx_t'(i)))) |
                                  (push_ok & (len_r == bat_pkg::idx_t'(i))));
    // insert moves every live entry at or above the index one cell up
    assign ctrl[i].shift = acc & ins_ok & (bat_pkg::idx_t'(i) > in_index) &
                           (bat_pkg::idx_t'(i) <= len_r);
    assign ctrl[i].live  = bat_pkg::idx_t'(i) < len_r;
    assign ctrl[i].sel   = in_index == bat_pkg::idx_t'(i);

    bat_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl[i]),
      .value_i (in_value),
      .left_i  (left),
      .hit_i   (hit_in),
      .entry_o (entry[i]),
      .rd_o    (rd_cell[i]),
      .hit_o   (hit_chain[i]),
      .first_o (first[i])
    );
  end

  // Collect the read word and the position of the lowest match
  always_comb begin
    bat_pkg::word_t rd_any;
    bat_pkg::idx_t  pos_any;
    rd_any  = '0;
    pos_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | rd_cell[i];
      if (first[i]) begin
        pos_any = pos_any | bat_pkg::idx_t'(i);
      end
    end
    rd_nxt    = get_ok ? rd_any : '0;
    found_nxt = '0;
    if (find_op) begin
      found_nxt = hit_chain[DEPTH-1] ? pos_any : '1;  // all ones means no match
    end
  end

  // Length after the command
  always_comb begin
    len_nxt = len_r;
    if (init_ok) begin
      len_nxt = in_index;
    end else if (push_ok | ins_ok) begin
      len_nxt = len_r + bat_pkg::idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        len_r       <= len_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: hold while stalled, load on accept
  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status_nxt;
      rd_r     <= rd_nxt;
      found_r  <= found_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, len_r, found_r, rd_r, status_r};

endmodule

// ===== src/bat_checker.sv =====
`timescale 1ns / 1ps

module bat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  logic [1:0] st;
  logic [4:0] len;

  assign st  = out_tdata[1:0];
  assign len = out_tdata[43:39];

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Length never exceeds capacity
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> len <= 5'(bat_pkg::DEPTH))
    else $error("length beyond capacity");

  // A full status only comes from a full table
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == bat_pkg::ST_FULL |-> len == 5'(bat_pkg::DEPTH))
    else $error("full status with room left");

  // A rejected command returns no read data
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != bat_pkg::ST_OK |-> out_tdata[33:2] == 32'd0)
    else $error("read data on a failed command");

  // An accepted word shows its result on the next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted word without a result");

endmodule

bind bounded_array_table bat_checker u_bat_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bat_pkg::*;

  // Codes 6 and 7 are not part of the command set; the table ignores them
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  localparam int IDLE_LIMIT      = 3000;  // cycles with no word moving on either side
  localparam int HOLD_OFF_CYCLES = 80;    // long receiver stall in the pressure test
  localparam int RANDOM_WORDS    = 1400;

  // One decoded result word
  typedef struct {
    logic [STAT_W-1:0] status;
    word_t             read_value;
    logic [IDX_W-1:0]  found_index;
    logic [IDX_W-1:0]  length;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;    // command[2:0], index[7:3], value[39:8]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;   // status[1:0], read_value[33:2],
                            // found_index[38:34], length[43:39]

  // Shadow copy of the table, advanced once per accepted input word
  word_t         table_cells [DEPTH];
  int            table_len = 0;
  table_result_t pending_results [$];

  int error_count  = 0;
  int words_sent   = 0;
  int bad_seen     = 0;
  int full_seen    = 0;
  int find_hits    = 0;
  int idle_cycles  = 0;
  int hold_request = 0;
  bit send_burst   = 1'b0;
  bit recv_burst   = 1'b0;
  bit no_send_gaps = 1'b0;

  bounded_array_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Execute one command on the shadow table and return the result it must produce
  function automatic table_result_t apply_command(logic [CMD_W-1:0] cmd, idx_t idx,
                                                  word_t val);
    table_result_t r;
    r.status      = ST_OK;
    r.read_value  = '0;
    r.found_index = '0;
    case (cmd)
      CMD_INIT: begin
        if (idx > DEPTH) begin
          r.status = ST_BAD_INDEX;
        end else begin
          foreach (table_cells[i]) table_cells[i] = '0;
          table_len = idx;
        end
      end
      CMD_GET: begin
        if (idx >= table_len) r.status = ST_BAD_INDEX;
        else r.read_value = table_cells[idx];
      end
      CMD_SET: begin
        if (idx >= table_len) r.status = ST_BAD_INDEX;
        else table_cells[idx] = val;
      end
      CMD_PUSH: begin
        if (table_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          table_cells[table_len] = val;
          table_len++;
        end
      end
      CMD_INSERT: begin
        // range is checked ahead of fullness
        if (idx >= table_len) begin
          r.status = ST_BAD_INDEX;
        end else if (table_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = table_len; i > idx; i--) table_cells[i] = table_cells[i-1];
          table_cells[idx] = val;
          table_len++;
        end
      end
      CMD_FIND: begin
        // scan downward so the lowest match is the one that sticks
        r.found_index = '1;
        for (int i = table_len - 1; i >= 0; i--)
          if (table_cells[i] == val) r.found_index = IDX_W'(i);
      end
      default: ;
    endcase
    r.length = IDX_W'(table_len);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Offer one word, hold it until accepted, then record its expected result
  task automatic send_word(logic [CMD_W-1:0] cmd, idx_t idx, word_t val);
    int            gap;
    table_result_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= {val, idx, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = apply_command(cmd, idx, val);
    pending_results = {pending_results, r};
    words_sent++;
    if (r.status == ST_BAD_INDEX) bad_seen++;
    if (r.status == ST_FULL) full_seen++;
    if (cmd == CMD_FIND && r.found_index != '1) find_hits++;
    // switch between back-to-back stretches and gappy stretches now and then
    if ($urandom_range(0, 59) == 0) send_burst = !send_burst;
    gap = (send_burst || no_send_gaps) ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Compare one result word against the oldest expectation
  task automatic check_result(logic [47:0] word);
    table_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending", word[31:0], '0);
      return;
    end
    want = pending_results.pop_front();
    if (word[1:0] !== want.status)
      report_mismatch("status", word[1:0], want.status);
    if (word[33:2] !== want.read_value)
      report_mismatch("read_value", word[33:2], want.read_value);
    if (word[38:34] !== want.found_index)
      report_mismatch("found_index", word[38:34], want.found_index);
    if (word[43:39] !== want.length)
      report_mismatch("length", word[43:39], want.length);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_tvalid && out_tready) check_result(out_tdata);
  end

  // Receiver: random stalls, burst stretches, and a long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 59) == 0) recv_burst = !recv_burst;
        if (!recv_burst) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Extremes, every command, every error path and the ignored codes
  task automatic test_directed();
    send_word(CMD_GET,    5'd0,  32'sd0);            // get on empty table
    send_word(CMD_FIND,   5'd0,  32'sd0);            // find on empty table
    send_word(CMD_INSERT, 5'd0,  32'sd5);            // insert on empty table
    send_word(CMD_INIT,   5'd16, 32'sd0);            // largest length
    send_word(CMD_INIT,   5'd17, 32'sd0);            // length one past capacity
    send_word(CMD_INIT,   5'd31, 32'hFFFF_FFFF);     // all index bits set
    send_word(CMD_SET,    5'd0,  32'h7FFF_FFFF);
    send_word(CMD_SET,    5'd15, 32'h8000_0000);
    send_word(CMD_GET,    5'd15, 32'sd0);
    send_word(CMD_GET,    5'd16, 32'sd0);            // read past the end
    send_word(CMD_SET,    5'd16, 32'sd1);            // write past the end
    send_word(CMD_PUSH,   5'd0,  32'sd1);            // append to full table
    send_word(CMD_INSERT, 5'd3,  32'sd2);            // insert into full table
    send_word(CMD_INSERT, 5'd16, 32'sd2);            // bad index wins over full
    send_word(CMD_FIND,   5'd0,  32'h7FFF_FFFF);
    send_word(CMD_FIND,   5'd0,  32'h8000_0000);
    send_word(CMD_FIND,   5'd0,  32'sd0);
    send_word(CMD_FIND,   5'd0,  32'h1234_5678);     // miss on full table
    send_word(CMD_SPARE6, 5'd31, 32'hFFFF_FFFF);
    send_word(CMD_SPARE7, 5'd31, 32'hFFFF_FFFF);
    send_word(CMD_INIT,   5'd0,  32'sd0);
    send_word(CMD_PUSH,   5'd0,  32'hFFFF_FFFF);
    send_word(CMD_INSERT, 5'd0,  32'sd5);            // insert at the front
    send_word(CMD_GET,    5'd1,  32'sd0);
    send_word(CMD_FIND,   5'd0,  32'hFFFF_FFFF);
    send_word(CMD_INIT,   5'd5,  32'sd0);
    send_word(CMD_GET,    5'd4,  32'sd0);            // entries cleared by init
  endtask

  // Stall the receiver for a long stretch while words keep coming
  task automatic test_backpressure();
    no_send_gaps = 1'b1;
    hold_request = HOLD_OFF_CYCLES;
    send_word(CMD_INIT, 5'd0, 32'sd0);
    repeat (DEPTH + 2) send_word(CMD_PUSH, 5'd0, word_t'($urandom));
    send_word(CMD_FIND, 5'd0, table_cells[$urandom_range(0, DEPTH - 1)]);
    no_send_gaps = 1'b0;
  endtask

  // Biased value: often one already in the table so finds hit
  function automatic word_t pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4 && table_len > 0) return table_cells[$urandom_range(0, table_len - 1)];
    if (roll == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return word_t'($urandom);
  endfunction

  // Mostly in-range commands on a live table, with some out-of-range noise
  task automatic test_random(int count);
    int               roll;
    logic [CMD_W-1:0] cmd;
    idx_t             idx;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (table_len > 0 && $urandom_range(0, 9) != 0)
        idx = idx_t'($urandom_range(0, table_len - 1));
      else
        idx = idx_t'($urandom_range(0, 31));
      if (roll < 4) begin
        cmd = CMD_INIT;
        idx = ($urandom_range(0, 4) != 0) ? idx_t'($urandom_range(0, DEPTH))
                                          : idx_t'($urandom_range(DEPTH + 1, 31));
      end
      else if (roll < 22) cmd = CMD_GET;
      else if (roll < 36) cmd = CMD_SET;
      else if (roll < 54) cmd = CMD_PUSH;
      else if (roll < 70) cmd = CMD_INSERT;
      else if (roll < 96) cmd = CMD_FIND;
      else cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
      send_word(cmd, idx, pick_value());
    end
  endtask

  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    rst_n     <= 1'b0;
    foreach (table_cells[i]) table_cells[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random(RANDOM_WORDS);

    // drain: drop valid, wait for every pending result, then idle before the summary
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Covered %0d words: %0d out-of-range, %0d table-full, %0d find hits,",
             words_sent, bad_seen, full_seen, find_hits);
    $display("plus a %0d-cycle receiver hold-off with the input stalled.",
             HOLD_OFF_CYCLES);
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
